// File: rtl/nearest_speaker_panner_unit_defines.svh
// Assertion macros shared by the checker
`ifndef NEAREST_SPEAKER_PANNER_UNIT_DEFINES_SVH
`define NEAREST_SPEAKER_PANNER_UNIT_DEFINES_SVH

// Implication checked on every clock, quiet while reset is active
`define NSP_ASSERT_IMP(label, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication with the consequent checked in the following cycle
`define NSP_ASSERT_NEXT(label, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/nsp_pkg.sv
package nsp_pkg;
	localparam int MAX_SPEAKERS = 64;
	localparam int IDX_W        = 6;
	localparam int CNT_W        = 7;
	localparam int ANGLE_BITS   = 16;
	localparam int FRAC_BITS    = ANGLE_BITS - 7;
	localparam int LEN_W        = 21;
	localparam int POS_W        = 20;
	localparam int SAMP_W       = 24;
	localparam int ADDR_W       = 26;
	localparam int TRIG_W       = 17;
	localparam int COS_W        = 64;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_PAN  = 1'b1;

	localparam logic CFG_NUM_SPEAKERS = 1'b0;
	localparam logic CFG_RESP_LENGTH  = 1'b1;

	typedef logic [ANGLE_BITS-1:0] angle_t;
	typedef logic signed [TRIG_W-1:0] trig_t;

	// One item moving down the speaker chain
	typedef struct packed {
		logic                     vld;
		logic                     ld;
		logic [IDX_W-1:0]         widx;
		logic                     found;
		logic [IDX_W-1:0]         best;
		logic signed [COS_W-1:0]  best_c;
		trig_t                    se0;
		trig_t                    ce0;
		angle_t                   az0;
		logic signed [SAMP_W-1:0] samp;
		logic [POS_W-1:0]         pos;
	} lane_t;

	// Quarter-wave sine table, Q15 with one at 32768
	function automatic logic [16:0] sine_tab(input logic [5:0] i);
		logic [16:0] v;
		unique case (i)
			6'd0: v = 17'd0;       6'd1: v = 17'd1608;   6'd2: v = 17'd3212;
			6'd3: v = 17'd4808;    6'd4: v = 17'd6393;   6'd5: v = 17'd7962;
			6'd6: v = 17'd9512;    6'd7: v = 17'd11039;  6'd8: v = 17'd12540;
			6'd9: v = 17'd14010;   6'd10: v = 17'd15447; 6'd11: v = 17'd16846;
			6'd12: v = 17'd18205;  6'd13: v = 17'd19520; 6'd14: v = 17'd20788;
			6'd15: v = 17'd22006;  6'd16: v = 17'd23170; 6'd17: v = 17'd24279;
			6'd18: v = 17'd25330;  6'd19: v = 17'd26320; 6'd20: v = 17'd27246;
			6'd21: v = 17'd28106;  6'd22: v = 17'd28899; 6'd23: v = 17'd29622;
			6'd24: v = 17'd30274;  6'd25: v = 17'd30853; 6'd26: v = 17'd31357;
			6'd27: v = 17'd31786;  6'd28: v = 17'd32138; 6'd29: v = 17'd32413;
			6'd30: v = 17'd32610;  6'd31: v = 17'd32729;
			default: v = 17'd32768;
		endcase
		return v;
	endfunction

	function automatic logic [16:0] quarter_sine(input logic [ANGLE_BITS-2:0] x);
		logic [ANGLE_BITS-2-FRAC_BITS:0] i;
		logic [FRAC_BITS-1:0]            f;
		logic [16:0]                     a;
		logic [16:0]                     d;
		logic [16+FRAC_BITS:0]           p;
		i = x[ANGLE_BITS-2:FRAC_BITS];
		f = x[FRAC_BITS-1:0];
		a = sine_tab(6'(i));
		d = sine_tab(6'(i) + 6'd1) - a;
		p = (FRAC_BITS+17)'(d) * (FRAC_BITS+17)'(f);
		return a + 17'(p >> FRAC_BITS);
	endfunction

	function automatic trig_t sine_of(input angle_t ph);
		logic [ANGLE_BITS-1:0] r;
		logic [ANGLE_BITS-2:0] m;
		logic [16:0]           s;
		r = {2'b00, ph[ANGLE_BITS-3:0]};
		if (ph[ANGLE_BITS-2]) begin
			r = (ANGLE_BITS)'(1 << (ANGLE_BITS-2)) - r;
		end
		if (r[ANGLE_BITS-2]) begin
			s = 17'd32768;
		end else begin
			m = r[ANGLE_BITS-2:0];
			s = quarter_sine(m);
		end
		return ph[ANGLE_BITS-1] ? -$signed(s) : $signed(s);
	endfunction

	function automatic trig_t cosine_of(input angle_t ph);
		return sine_of(ph + angle_t'(1 << (ANGLE_BITS-2)));
	endfunction
endpackage

// File: rtl/nsp_front.sv
// Entry stage: trig of the item elevation
module nsp_front import nsp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     in_vld,
	input  logic                     in_ld,
	input  logic [IDX_W-1:0]         widx,
	input  angle_t                   az,
	input  angle_t                   el,
	input  logic signed [SAMP_W-1:0] samp,
	input  logic [POS_W-1:0]         pos,
	output lane_t                    lane_s1
);
	lane_t lane_n;

	// Build the lane entry; load items carry their speaker trig down the chain
	always_comb begin
		lane_n      = '0;
		lane_n.vld  = in_vld;
		lane_n.ld   = in_ld;
		lane_n.widx = widx;
		lane_n.se0  = sine_of(el);
		lane_n.ce0  = cosine_of(el);
		lane_n.az0  = az;
		lane_n.samp = samp;
		lane_n.pos  = pos;
	end

	// Launch the item into the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_s1 <= '0;
		end else if (adv) begin
			lane_s1 <= lane_n;
		end
	end
endmodule

// File: rtl/nsp_cell.sv
// One speaker of the chain: three register stages per speaker
module nsp_cell import nsp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic [IDX_W-1:0] idx,
	input  logic             active,
	input  lane_t            lane_in,
	output lane_t            lane_out
);
	angle_t az_q;
	trig_t  se1_q, ce1_q;
	lane_t  lane_s1, lane_s2, lane_n;
	trig_t  cd_s1;
	logic signed [TRIG_W-1:0] ce1_s1, se1_s1;
	logic signed [2*TRIG_W-1:0] ss_s2, cc_s2;
	trig_t cd_s2;
	logic signed [3*TRIG_W-1:0] ccd_n;
	logic signed [COS_W-1:0] c_n;

	// Store the speaker direction when its load item passes, in item order
	always_ff @(posedge clk) begin
		if (adv && lane_in.ld && lane_in.widx == idx) begin
			az_q  <= lane_in.az0;
			se1_q <= lane_in.se0;
			ce1_q <= lane_in.ce0;
		end
	end

	assign ccd_n = cc_s2 * cd_s2;
	assign c_n   = (COS_W'(ss_s2) <<< 15) + COS_W'(ccd_n);

	// Keep the first speaker with the strictly largest cosine
	always_comb begin
		lane_n = lane_s2;
		if (active && (!lane_s2.found || c_n > lane_s2.best_c)) begin
			lane_n.found  = 1'b1;
			lane_n.best   = idx;
			lane_n.best_c = c_n;
		end
	end

	// Advance the lane with its valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_s1  <= '0;
			lane_s2  <= '0;
			lane_out <= '0;
		end else if (adv) begin
			lane_s1  <= lane_in;
			lane_s2  <= lane_s1;
			lane_out <= lane_n;
		end
	end

	// Stage 1: azimuth difference cosine; stage 2: products
	always_ff @(posedge clk) begin
		if (adv) begin
			cd_s1  <= cosine_of(az_q - lane_in.az0);
			se1_s1 <= se1_q;
			ce1_s1 <= ce1_q;
			ss_s2  <= lane_s1.se0 * se1_s1;
			cc_s2  <= lane_s1.ce0 * ce1_s1;
			cd_s2  <= cd_s1;
		end
	end
endmodule

// File: rtl/nsp_back.sv
// Exit stages: address multiply, then the output register
module nsp_back import nsp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  lane_t                    lane_in,
	input  logic [LEN_W-1:0]         len,
	output logic                     out_vld,
	output logic [IDX_W-1:0]         ch,
	output logic signed [SAMP_W-1:0] samp,
	output logic [POS_W-1:0]         pos,
	output logic [ADDR_W-1:0]        addr
);
	logic                     vld_s1;
	logic [IDX_W-1:0]         ch_s1;
	logic signed [SAMP_W-1:0] samp_s1;
	logic [POS_W-1:0]         pos_s1;
	logic [ADDR_W-1:0]        prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			out_vld <= 1'b0;
		end else if (adv) begin
			vld_s1  <= lane_in.vld;
			out_vld <= vld_s1;
		end
	end

	// Multiply then add position
	always_ff @(posedge clk) begin
		if (adv) begin
			ch_s1   <= lane_in.best;
			samp_s1 <= lane_in.samp;
			pos_s1  <= lane_in.pos;
			prod_s1 <= ADDR_W'((IDX_W+LEN_W)'(lane_in.best) * (IDX_W+LEN_W)'(len));
			ch      <= ch_s1;
			samp    <= samp_s1;
			pos     <= pos_s1;
			addr    <= prod_s1 + ADDR_W'(pos_s1);
		end
	end
endmodule

// File: rtl/nearest_speaker_panner_unit.sv
// A sample item passes the entry register, the speaker cells and the exit stages
//   before its result can be taken.
// Throughput: one item per cycle while the output is not stalled; each of the 64 speakers owns three stages.
// Load items travel the chain too, write their speaker in order, leave no result.
// arst_n clears lanes, valid bits and config registers; the speaker table stays undefined.
module nearest_speaker_panner_unit import nsp_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          op,
	input  logic [IDX_W-1:0]              speaker_index,
	input  logic signed [ANGLE_BITS-1:0]  azimuth,
	input  logic signed [ANGLE_BITS-1:0]  elevation,
	input  logic signed [SAMP_W-1:0]      sample_value,
	input  logic [POS_W-1:0]              sample_position,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [LEN_W-1:0]              cfg_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [IDX_W-1:0]              channel,
	output logic signed [SAMP_W-1:0]      routed_sample,
	output logic [POS_W-1:0]              routed_position,
	output logic [ADDR_W-1:0]             write_address
);
	logic [CNT_W-1:0] nspk_q;
	logic [LEN_W-1:0] len_q;
	logic             adv;
	logic             acc;
	lane_t            chain [MAX_SPEAKERS+1];

	// Whole pipe advances unless a held result is stalled
	assign adv       = !(out_valid && out_stall);
	assign in_stall  = !adv;
	assign cfg_ready = 1'b1;
	assign acc       = in_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nspk_q <= '0;
			len_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_NUM_SPEAKERS: nspk_q <= CNT_W'(cfg_data);
				CFG_RESP_LENGTH:  len_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	nsp_front u_front (
		.clk, .arst_n, .adv,
		.in_vld (acc && op == OP_PAN),
		.in_ld  (acc && op == OP_LOAD),
		.widx   (speaker_index),
		.az     (azimuth),
		.el     (elevation),
		.samp   (sample_value),
		.pos    (sample_position),
		.lane_s1(chain[0])
	);

	for (genvar g = 0; g < MAX_SPEAKERS; g++) begin : g_cell
		nsp_cell u_cell (
			.clk, .arst_n, .adv,
			.idx     (IDX_W'(g)),
			.active  (CNT_W'(g) < nspk_q),
			.lane_in (chain[g]),
			.lane_out(chain[g+1])
		);
	end

	nsp_back u_back (
		.clk, .arst_n, .adv,
		.lane_in(chain[MAX_SPEAKERS]),
		.len    (len_q),
		.out_vld(out_valid),
		.ch     (channel),
		.samp   (routed_sample),
		.pos    (routed_position),
		.addr   (write_address)
	);
endmodule

// File: rtl/nsp_checker.sv
`include "nearest_speaker_panner_unit_defines.svh"

// Port-level checks on the panner
module nsp_checker import nsp_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [IDX_W-1:0]  channel,
	input logic [ADDR_W-1:0] write_address
);
	`NSP_ASSERT_NEXT(a_out_hold, arst_n, out_valid && out_stall, out_valid && $stable(channel) && $stable(write_address), "stalled result changed")
	`NSP_ASSERT_IMP(a_in_stall, arst_n, in_stall, out_valid && out_stall, "input stalled without output stall")
	`NSP_ASSERT_IMP(a_free, arst_n, !out_stall, !in_stall, "input stalled while output free")
endmodule

bind nearest_speaker_panner_unit nsp_checker u_nsp_checker (
	.clk, .arst_n, .in_stall, .out_valid, .out_stall, .channel, .write_address
);

// File: tb/sv/nearest_speaker_panner_unit_test.sv
`timescale 1ns / 100ps

module nearest_speaker_panner_unit_test;
	import nsp_pkg::*;

	localparam int PIPE_CYCLES = 3*64 + 2;
	localparam int SETTLE      = PIPE_CYCLES + 20;
	localparam int HOLD_LONG   = 700;
	localparam int WATCHDOG    = 20000;

	typedef struct {
		logic                     op;
		logic [IDX_W-1:0]         idx;
		logic [15:0]              az;
		logic [15:0]              el;
		logic [SAMP_W-1:0]        samp;
		logic [POS_W-1:0]         pos;
	} pan_item_t;

	typedef struct {
		logic [IDX_W-1:0]  chan;
		logic [SAMP_W-1:0] samp;
		logic [POS_W-1:0]  pos;
		logic [ADDR_W-1:0] addr;
	} routed_t;

	localparam int SINE_Q15 [33] = '{
		0, 1608, 3212, 4808, 6393, 7962, 9512, 11039,
		12540, 14010, 15447, 16846, 18205, 19520, 20788, 22006,
		23170, 24279, 25330, 26320, 27246, 28106, 28899, 29622,
		30274, 30853, 31357, 31786, 32138, 32413, 32610, 32729,
		32768
	};

	logic clk;
	logic arst_n;
	logic in_valid, in_stall;
	logic op;
	logic [IDX_W-1:0] speaker_index;
	logic signed [15:0] azimuth, elevation;
	logic signed [SAMP_W-1:0] sample_value;
	logic [POS_W-1:0] sample_position;
	logic cfg_valid, cfg_ready, cfg_index;
	logic [LEN_W-1:0] cfg_data;
	logic out_valid, out_stall;
	logic [IDX_W-1:0] channel;
	logic signed [SAMP_W-1:0] routed_sample;
	logic [POS_W-1:0] routed_position;
	logic [ADDR_W-1:0] write_address;

	// testbench copy of the block state
	logic [31:0] spk_dir [MAX_SPEAKERS];
	int unsigned spk_count;
	int unsigned resp_stride;

	pan_item_t pending_items [$];
	routed_t   routes_due [$];
	int mismatches = 0;
	int pans_sent = 0, loads_sent = 0, routes_seen = 0, phases_run = 0;
	int idle_cycles = 0;
	bit accepted = 0;
	bit sender_hold = 1;
	bit long_hold_req = 0;
	int burst_left = 1, gap_left = 0;
	int hold_left = 0, stall_mode = 0, mode_left = 0;

	nearest_speaker_panner_unit DUT (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		in_valid = 0; op = OP_LOAD; speaker_index = '0; azimuth = '0; elevation = '0;
		sample_value = '0; sample_position = '0;
		cfg_valid = 0; cfg_index = CFG_NUM_SPEAKERS; cfg_data = '0;
		out_stall = 0;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1;
	end

	function automatic int quarter_wave(int unsigned x);
		int unsigned i, f;
		i = x >> FRAC_BITS;
		f = x & ((1 << FRAC_BITS) - 1);
		if (i >= 32) return 32768;
		return SINE_Q15[i] + (((SINE_Q15[i+1] - SINE_Q15[i]) * f) >> FRAC_BITS);
	endfunction

	function automatic int sin_q15(logic [15:0] ph);
		int unsigned r;
		r = ph[13:0];
		case (ph[15:14])
			2'd0: return quarter_wave(r);
			2'd1: return quarter_wave(16384 - r);
			2'd2: return -quarter_wave(r);
			default: return -quarter_wave(16384 - r);
		endcase
	endfunction

	function automatic int cos_q15(logic [15:0] ph);
		return sin_q15(ph + 16'h4000);
	endfunction

	// pick the nearest speaker for one sample
	function automatic routed_t route_sample(pan_item_t it);
		routed_t r;
		longint se0, ce0, c, best_c;
		logic [15:0] az1, el1;
		int unsigned n, best;
		bit found;
		longint addr;
		se0 = sin_q15(it.el);
		ce0 = cos_q15(it.el);
		n = spk_count > MAX_SPEAKERS ? MAX_SPEAKERS : spk_count;
		best = 0; best_c = 0; found = 0;
		for (int j = 0; j < n; j++) begin
			az1 = spk_dir[j][31:16];
			el1 = spk_dir[j][15:0];
			c = se0 * longint'(sin_q15(el1)) * 32768
			  + ce0 * longint'(cos_q15(el1)) * longint'(cos_q15(az1 - it.az));
			if (!found || c > best_c) begin
				found = 1; best_c = c; best = j;
			end
		end
		addr = longint'(best) * longint'(resp_stride) + longint'(it.pos);
		r.chan = best[IDX_W-1:0];
		r.samp = it.samp;
		r.pos  = it.pos;
		r.addr = addr[ADDR_W-1:0];
		return r;
	endfunction

	// feed items in bursts with gaps
	always @(negedge clk) begin
		if (!in_valid || accepted) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 0;
			end else if (!sender_hold && pending_items.size() > 0) begin
				pan_item_t it;
				it = pending_items.pop_front();
				op <= it.op; speaker_index <= it.idx; azimuth <= it.az; elevation <= it.el;
				sample_value <= it.samp; sample_position <= it.pos;
				in_valid <= 1;
				if (--burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 0;
			end
		end
		accepted = 0;
	end

	// stall the result side on a shifting pattern, with one long hold
	always @(negedge clk) begin
		if (long_hold_req && hold_left == 0) begin
			hold_left = HOLD_LONG;
			long_hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1;
		end else begin
			if (mode_left <= 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			case (stall_mode)
				0: out_stall <= 0;
				1: out_stall <= ($urandom_range(0, 9) < 3);
				default: out_stall <= ($urandom_range(0, 9) < 7);
			endcase
		end
	end

	// predict on accepted input items
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			pan_item_t it;
			accepted = 1;
			it.op = op; it.idx = speaker_index; it.az = azimuth; it.el = elevation;
			it.samp = sample_value; it.pos = sample_position;
			if (op == OP_LOAD) begin
				spk_dir[speaker_index] = {azimuth, elevation};
				loads_sent++;
			end else begin
				routes_due = {routes_due, route_sample(it)};
				pans_sent++;
			end
		end
	end

	// compare routed samples with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			routes_seen++;
			if (routes_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: ch=%0d samp=%h pos=%h addr=%h",
						channel, routed_sample, routed_position, write_address);
			end else begin
				routed_t e;
				e = routes_due.pop_front();
				if (channel !== e.chan || routed_sample !== e.samp ||
				    routed_position !== e.pos || write_address !== e.addr) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp ch=%0d samp=%h pos=%h addr=%h,",
							e.chan, e.samp, e.pos, e.addr,
							" got ch=%0d samp=%h pos=%h addr=%h",
							channel, routed_sample, routed_position, write_address);
				end
			end
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG) begin
			$display("watchdog: no progress, %0d results still due", routes_due.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic write_reg(logic idx, int unsigned val);
		@(negedge clk);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val[LEN_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_NUM_SPEAKERS) spk_count = val & 32'h7F;
		else resp_stride = val & 32'h1FFFFF;
		@(negedge clk) cfg_valid <= 0;
	endtask

	task automatic drain;
		sender_hold = 0;
		wait (pending_items.size() == 0 && !in_valid && routes_due.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic void add_load(int idx, logic [15:0] az, logic [15:0] el);
		pan_item_t it;
		it.op = OP_LOAD; it.idx = IDX_W'(idx); it.az = az; it.el = el;
		it.samp = SAMP_W'($urandom); it.pos = POS_W'($urandom);
		pending_items = {pending_items, it};
	endfunction

	function automatic void add_pan(logic [15:0] az, logic [15:0] el,
		logic [SAMP_W-1:0] s, logic [POS_W-1:0] p);
		pan_item_t it;
		it.op = OP_PAN; it.idx = IDX_W'($urandom); it.az = az; it.el = el;
		it.samp = s; it.pos = p;
		pending_items = {pending_items, it};
	endfunction

	function automatic logic [15:0] rand_angle();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 3) * 16'h4000);
			1: return 16'($urandom_range(0, 1) ? 16'h8000 : 16'h7FFF);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void add_random(int count);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 3) == 0)
				add_load($urandom_range(0, 63), rand_angle(), rand_angle());
			else if ($urandom_range(0, 4) == 0) begin
				logic [31:0] d;
				d = spk_dir[$urandom_range(0, 63)];
				add_pan(d[31:16], d[15:0], SAMP_W'($urandom), POS_W'($urandom));
			end else
				add_pan(rand_angle(), rand_angle(), SAMP_W'($urandom), POS_W'($urandom));
		end
	endfunction

	initial begin
		automatic int unsigned counts [6] = '{1, 64, 2, 100, 127, 33};
		automatic int unsigned lens [6]   = '{1048576, 0, 2097151, 1, 4095, 777777};
		wait (arst_n);
		@(posedge clk);

		// no speakers: channel stays 0, field extremes pass through
		write_reg(CFG_NUM_SPEAKERS, 0);
		write_reg(CFG_RESP_LENGTH, 0);
		add_pan(16'h8000, 16'h7FFF, 24'h800000, 20'hFFFFF);
		add_pan(16'h7FFF, 16'h8000, 24'h7FFFFF, 20'h00000);
		add_pan(16'h0000, 16'h0000, 24'hFFFFFF, 20'h80000);
		// fill the whole table before any search reads it
		for (int j = 0; j < MAX_SPEAKERS; j++)
			add_load(j, 16'($urandom), 16'($urandom));
		// duplicate directions to force ties: first index must win
		add_load(3, 16'h2000, 16'h1000);
		add_load(1, 16'h2000, 16'h1000);
		add_load(0, 16'h8000, 16'h8000);
		add_load(63, 16'h4000, 16'h7FFF);
		drain();
		phases_run++;

		// full table, stride 1048576
		write_reg(CFG_NUM_SPEAKERS, 64);
		write_reg(CFG_RESP_LENGTH, 1048576);
		add_pan(16'h2000, 16'h1000, 24'h123456, 20'hFFFFF);
		add_pan(16'h8000, 16'h8000, 24'h800000, 20'h00001);
		add_pan(16'h4000, 16'h7FFF, 24'h7FFFFF, 20'hFFFFF);
		add_pan(16'h7FFF, 16'h4000, 24'h000000, 20'h00000);
		add_pan(16'hC000, 16'hC000, 24'h000001, 20'h12345);
		drain();
		phases_run++;

		for (int p = 0; p < 6; p++) begin
			write_reg(CFG_NUM_SPEAKERS, counts[p]);
			write_reg(CFG_RESP_LENGTH, lens[p]);
			add_random(120);
			// let the pipeline back up behind a long output stall
			if (p == 1) long_hold_req = 1;
			drain();
			// second half after a full pause of the sender
			add_random(130);
			drain();
			phases_run++;
		end

		$display("covered %0d load items, %0d sample items, %0d results over %0d settings",
			loads_sent, pans_sent, routes_seen, phases_run);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else begin
			$display("%0d mismatches", mismatches);
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

// File: filelist.f
+incdir+rtl
rtl/nsp_pkg.sv
rtl/nsp_front.sv
rtl/nsp_cell.sv
rtl/nsp_back.sv
rtl/nearest_speaker_panner_unit.sv
rtl/nsp_checker.sv
tb/sv/nearest_speaker_panner_unit_test.sv
